// ----- rtl/core/atsmp_pkg.sv -----
// Package: shared types, widths and codes for the alias table sampler.
package atsmp_pkg;

	localparam int MAX_OUTCOMES = 256;
	localparam int IDX_W = 8;
	localparam int CNT_W = 9;
	localparam int WEIGHT_W = 16;
	localparam int VALUE_W = 32;
	localparam int SUM_W = 24;
	localparam int TH_W = 25;
	localparam int ALU_A_W = 33;
	localparam int ALU_B_W = 25;
	localparam int ALU_R_W = ALU_A_W + ALU_B_W;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_BUILD = 2'd1;
	localparam logic [1:0] MODE_SAMPLE = 2'd2;

	localparam logic KIND_BUILD = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_ZERO = 2'd1;
	localparam logic [1:0] STATUS_UNBUILT = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [IDX_W-1:0] entry_index;
		logic [WEIGHT_W-1:0] weight;
		logic [VALUE_W-1:0] entry_value;
		logic [31:0] uniform;
	} item_t;

	typedef struct packed {
		logic result_kind;
		logic [1:0] status;
		logic [IDX_W-1:0] outcome_index;
		logic [VALUE_W-1:0] outcome_value;
	} result_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SUM_RD,
		S_SUM_ACC,
		S_SUM_WB,
		S_TH_RD,
		S_TH_MUL,
		S_TH_WR,
		S_P_CHK,
		S_P_RD_TH,
		S_P_ADD,
		S_P_SUB,
		S_P_WR,
		S_X_MUL,
		S_X_RD,
		S_F_MUL,
		S_CMP,
		S_VAL,
		S_DONE
	} state_t;

endpackage

// ----- rtl/core/atsmp_alu.sv -----
// Shared arithmetic unit: add, subtract or multiply with a registered result.
module atsmp_alu (
	input  logic clk,
	input  atsmp_pkg::alu_op_t op,
	input  logic [atsmp_pkg::ALU_A_W-1:0] a,
	input  logic [atsmp_pkg::ALU_B_W-1:0] b,
	output logic [atsmp_pkg::ALU_R_W-1:0] res
);

	logic [atsmp_pkg::ALU_R_W-1:0] res_q;
	logic [atsmp_pkg::ALU_R_W-1:0] a_ext;
	logic [atsmp_pkg::ALU_R_W-1:0] b_ext;

	assign a_ext = {{atsmp_pkg::ALU_B_W{1'b0}}, a};
	assign b_ext = {{atsmp_pkg::ALU_A_W{1'b0}}, b};
	assign res = res_q;

	always_ff @(posedge clk) begin
		case (op)
			atsmp_pkg::ALU_ADD: res_q <= a_ext + b_ext;
			atsmp_pkg::ALU_SUB: res_q <= a_ext - b_ext;
			default: res_q <= a_ext * b_ext;
		endcase
	end

endmodule

// ----- rtl/core/alias_table_sampler.sv -----
// Alias table sampler top level: handshakes, stores and build/sample sequencer.
// Weight write: stored on accept. Sample: index multiply, table read, fraction multiply,
// compare, value read (unbuilt: straight to result). Build: summing, scaling, pairing.
// One item at a time; the shared add/multiply unit and store ports set the pace.
// Reset: count 1, tables not built, all weights and values read as zero.
module alias_table_sampler (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  atsmp_pkg::item_t item,
	output logic result_valid,
	input  logic result_ready,
	output atsmp_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [atsmp_pkg::CNT_W-1:0] cfg_data
);

	localparam int N = atsmp_pkg::MAX_OUTCOMES;
	localparam int IW = atsmp_pkg::IDX_W;
	localparam int CW = atsmp_pkg::CNT_W;

	atsmp_pkg::state_t state_q, state_d;

	logic [CW-1:0] num_q, n_eff, bn_q, i_q, ns_q, nb_q;
	logic [atsmp_pkg::SUM_W-1:0] sum_q;
	logic ready_q;
	logic [31:0] u_q;
	logic [IW-1:0] k_q, j_q, idx_q, pick_q;
	logic [32:0] frac_q;
	atsmp_pkg::result_t res_q, out_q;
	logic out_valid_q;

	// stores
	logic [atsmp_pkg::WEIGHT_W-1:0] w_mem [N];
	logic [atsmp_pkg::VALUE_W-1:0] v_mem [N];
	logic [atsmp_pkg::TH_W-1:0] th_mem [N];
	logic [IW-1:0] al_mem [N];
	logic [IW-1:0] sm_mem [N];
	logic [IW-1:0] bg_mem [N];
	logic [N-1:0] ent_vld_q;

	logic [atsmp_pkg::WEIGHT_W-1:0] w_rd_q;
	logic wv_rd_q;
	logic [atsmp_pkg::VALUE_W-1:0] v_rd_q;
	logic vv_rd_q;
	logic [atsmp_pkg::TH_W-1:0] th_a_q, th_b_q;
	logic [IW-1:0] al_rd_q, sm_rd_q, bg_rd_q;

	// ALU
	atsmp_pkg::alu_op_t alu_op;
	logic [atsmp_pkg::ALU_A_W-1:0] alu_a;
	logic [atsmp_pkg::ALU_B_W-1:0] alu_b;
	logic [atsmp_pkg::ALU_R_W-1:0] alu_res;

	atsmp_alu u_alu (
		.clk(clk),
		.op(alu_op),
		.a(alu_a),
		.b(alu_b),
		.res(alu_res)
	);

	logic acc, out_free, cfg_wr;
	logic [atsmp_pkg::WEIGHT_W-1:0] w_eff;
	logic [atsmp_pkg::TH_W-1:0] th_new;
	logic [CW-1:0] idx_raw, idx_c;
	logic pick_self;
	logic [IW-1:0] pick_c;

	assign acc = item_valid && item_ready;
	assign out_free = !out_valid_q || result_ready;
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		if (num_q == '0) begin
			n_eff = CW'(1);
		end else if (num_q > CW'(N)) begin
			n_eff = CW'(N);
		end else begin
			n_eff = num_q;
		end
	end

	assign w_eff = wv_rd_q ? w_rd_q : '0;
	assign th_new = alu_res[atsmp_pkg::TH_W-1:0];
	assign idx_raw = alu_res[41:33];
	assign idx_c = (idx_raw >= bn_q) ? bn_q - CW'(1) : idx_raw;
	assign pick_self = alu_res <= {th_a_q, 33'b0};
	assign pick_c = pick_self ? idx_q : al_rd_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			atsmp_pkg::S_IDLE: begin
				if (acc) begin
					if (item.mode == atsmp_pkg::MODE_BUILD) begin
						state_d = atsmp_pkg::S_SUM_RD;
					end else if (item.mode == atsmp_pkg::MODE_SAMPLE) begin
						state_d = ready_q ? atsmp_pkg::S_X_MUL : atsmp_pkg::S_DONE;
					end
				end
			end
			atsmp_pkg::S_SUM_RD: state_d = (i_q == bn_q) ? atsmp_pkg::S_TH_RD
					: atsmp_pkg::S_SUM_ACC;
			atsmp_pkg::S_SUM_ACC: state_d = atsmp_pkg::S_SUM_WB;
			atsmp_pkg::S_SUM_WB: state_d = atsmp_pkg::S_SUM_RD;
			atsmp_pkg::S_TH_RD: state_d = (i_q == bn_q) ? atsmp_pkg::S_P_CHK
					: atsmp_pkg::S_TH_MUL;
			atsmp_pkg::S_TH_MUL: state_d = atsmp_pkg::S_TH_WR;
			atsmp_pkg::S_TH_WR: state_d = atsmp_pkg::S_TH_RD;
			atsmp_pkg::S_P_CHK: state_d = (ns_q == '0 || nb_q == '0) ? atsmp_pkg::S_DONE
					: atsmp_pkg::S_P_RD_TH;
			atsmp_pkg::S_P_RD_TH: state_d = atsmp_pkg::S_P_ADD;
			atsmp_pkg::S_P_ADD: state_d = atsmp_pkg::S_P_SUB;
			atsmp_pkg::S_P_SUB: state_d = atsmp_pkg::S_P_WR;
			atsmp_pkg::S_P_WR: state_d = atsmp_pkg::S_P_CHK;
			atsmp_pkg::S_X_MUL: state_d = atsmp_pkg::S_X_RD;
			atsmp_pkg::S_X_RD: state_d = atsmp_pkg::S_F_MUL;
			atsmp_pkg::S_F_MUL: state_d = atsmp_pkg::S_CMP;
			atsmp_pkg::S_CMP: state_d = atsmp_pkg::S_VAL;
			atsmp_pkg::S_VAL: state_d = atsmp_pkg::S_DONE;
			atsmp_pkg::S_DONE: state_d = out_free ? atsmp_pkg::S_IDLE : atsmp_pkg::S_DONE;
			default: state_d = atsmp_pkg::S_IDLE;
		endcase
	end

	// ALU operand selection
	always_comb begin
		alu_op = atsmp_pkg::ALU_ADD;
		alu_a = '0;
		alu_b = '0;
		item_ready = (state_q == atsmp_pkg::S_IDLE);
		unique case (state_q)
			atsmp_pkg::S_SUM_ACC: begin
				alu_op = atsmp_pkg::ALU_ADD;
				alu_a = {9'b0, sum_q};
				alu_b = {9'b0, w_eff};
			end
			atsmp_pkg::S_TH_MUL: begin
				alu_op = atsmp_pkg::ALU_MUL;
				alu_a = {24'b0, bn_q};
				alu_b = {9'b0, w_eff};
			end
			atsmp_pkg::S_P_ADD: begin
				alu_op = atsmp_pkg::ALU_ADD;
				alu_a = {8'b0, th_a_q};
				alu_b = th_b_q;
			end
			atsmp_pkg::S_P_SUB: begin
				alu_op = atsmp_pkg::ALU_SUB;
				alu_a = alu_res[32:0];
				alu_b = {1'b0, sum_q};
			end
			atsmp_pkg::S_X_MUL: begin
				alu_op = atsmp_pkg::ALU_MUL;
				alu_a = {u_q, 1'b1};
				alu_b = {16'b0, bn_q};
			end
			atsmp_pkg::S_F_MUL: begin
				alu_op = atsmp_pkg::ALU_MUL;
				alu_a = frac_q;
				alu_b = {1'b0, sum_q};
			end
			default: begin
				alu_op = atsmp_pkg::ALU_ADD;
			end
		endcase
	end

	// stores: writes and registered reads
	always_ff @(posedge clk) begin
		if (state_q == atsmp_pkg::S_IDLE && acc && item.mode == atsmp_pkg::MODE_WRITE) begin
			w_mem[item.entry_index] <= item.weight;
			v_mem[item.entry_index] <= item.entry_value;
		end
		if (state_q == atsmp_pkg::S_SUM_RD || state_q == atsmp_pkg::S_TH_RD) begin
			w_rd_q <= w_mem[i_q[IW-1:0]];
			wv_rd_q <= ent_vld_q[i_q[IW-1:0]];
		end
		if (state_q == atsmp_pkg::S_CMP) begin
			v_rd_q <= v_mem[pick_c];
			vv_rd_q <= ent_vld_q[pick_c];
		end
		if (state_q == atsmp_pkg::S_TH_WR) begin
			th_mem[i_q[IW-1:0]] <= th_new;
			al_mem[i_q[IW-1:0]] <= i_q[IW-1:0];
			if (th_new < {1'b0, sum_q}) begin
				sm_mem[ns_q[IW-1:0]] <= i_q[IW-1:0];
			end else begin
				bg_mem[nb_q[IW-1:0]] <= i_q[IW-1:0];
			end
		end
		if (state_q == atsmp_pkg::S_P_WR) begin
			th_mem[k_q] <= th_new;
			al_mem[j_q] <= k_q;
			if (th_new < {1'b0, sum_q}) begin
				sm_mem[ns_q[IW-1:0] - IW'(1)] <= k_q;
			end
		end
		if (state_q == atsmp_pkg::S_P_CHK) begin
			bg_rd_q <= bg_mem[nb_q[IW-1:0] - IW'(1)];
			sm_rd_q <= sm_mem[ns_q[IW-1:0] - IW'(1)];
		end
		if (state_q == atsmp_pkg::S_P_RD_TH) begin
			th_a_q <= th_mem[bg_rd_q];
			th_b_q <= th_mem[sm_rd_q];
		end
		if (state_q == atsmp_pkg::S_X_RD) begin
			th_a_q <= th_mem[idx_c[IW-1:0]];
			al_rd_q <= al_mem[idx_c[IW-1:0]];
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			atsmp_pkg::S_IDLE: begin
				u_q <= item.uniform;
				bn_q <= (acc && item.mode == atsmp_pkg::MODE_BUILD) ? n_eff : bn_q;
				i_q <= '0;
				sum_q <= (acc && item.mode == atsmp_pkg::MODE_BUILD) ? '0 : sum_q;
				ns_q <= '0;
				nb_q <= '0;
				res_q <= '{atsmp_pkg::KIND_SAMPLE, atsmp_pkg::STATUS_UNBUILT, '0, '0};
			end
			atsmp_pkg::S_SUM_RD: begin
				if (i_q == bn_q) begin
					i_q <= '0;
				end
			end
			atsmp_pkg::S_SUM_WB: begin
				sum_q <= alu_res[atsmp_pkg::SUM_W-1:0];
				i_q <= i_q + CW'(1);
			end
			atsmp_pkg::S_TH_WR: begin
				i_q <= i_q + CW'(1);
				if (th_new < {1'b0, sum_q}) begin
					ns_q <= ns_q + CW'(1);
				end else begin
					nb_q <= nb_q + CW'(1);
				end
			end
			atsmp_pkg::S_P_CHK: begin
				res_q <= '{atsmp_pkg::KIND_BUILD,
					(sum_q == '0) ? atsmp_pkg::STATUS_ZERO : atsmp_pkg::STATUS_OK, '0, '0};
			end
			atsmp_pkg::S_P_RD_TH: begin
				k_q <= bg_rd_q;
				j_q <= sm_rd_q;
			end
			atsmp_pkg::S_P_WR: begin
				// big entry drops to the small stack in the slot the small entry left
				if (th_new < {1'b0, sum_q}) begin
					nb_q <= nb_q - CW'(1);
				end else begin
					ns_q <= ns_q - CW'(1);
				end
			end
			atsmp_pkg::S_X_RD: begin
				idx_q <= idx_c[IW-1:0];
				frac_q <= alu_res[32:0];
			end
			atsmp_pkg::S_CMP: begin
				pick_q <= pick_c;
			end
			atsmp_pkg::S_VAL: begin
				res_q <= '{atsmp_pkg::KIND_SAMPLE, atsmp_pkg::STATUS_OK, pick_q,
					vv_rd_q ? v_rd_q : '0};
			end
			default: begin
				i_q <= i_q;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= atsmp_pkg::S_IDLE;
			num_q <= CW'(1);
			ready_q <= 1'b0;
			ent_vld_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == atsmp_pkg::S_IDLE && acc
					&& item.mode == atsmp_pkg::MODE_WRITE) begin
				ent_vld_q[item.entry_index] <= 1'b1;
			end
			if (state_q == atsmp_pkg::S_P_CHK && state_d == atsmp_pkg::S_DONE) begin
				ready_q <= (sum_q != '0);
			end
			if (cfg_wr) begin
				num_q <= cfg_data;
				ready_q <= 1'b0;
			end
			if (state_q == atsmp_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (state_q == atsmp_pkg::S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

endmodule

// ----- tb/sv/tb_alias_table_sampler.sv -----
// Self-checking testbench for the alias table sampler: directed table, then random phases.
module tb_alias_table_sampler;
	import atsmp_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_GOAL = 1900;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [32:0] FRAC_MASK = {33{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	// typed expectation riding along with the current word
	logic typed_en = 1'b0;
	result_t typed_res = '0;

	int send_idle = 17;
	int recv_idle = 63;
	int errors = 0;
	int cycles = 0;
	int items_sent = 0;

	// predictor state
	logic [CNT_W-1:0] count_reg = 9'd1;
	logic [WEIGHT_W-1:0] weight_mem [MAX_OUTCOMES];
	logic [VALUE_W-1:0] value_mem [MAX_OUTCOMES];
	longint unsigned thresh_mem [MAX_OUTCOMES];
	int alias_mem [MAX_OUTCOMES];
	longint unsigned total_w = 0;
	bit tables_built = 1'b0;
	int built_n = 1;

	result_t pending_results [$];

	alias_table_sampler u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int eff_count(logic [CNT_W-1:0] c);
		if (c == 0) return 1;
		if (c > MAX_OUTCOMES) return MAX_OUTCOMES;
		return int'(c);
	endfunction

	function automatic void build_alias(int n);
		int small_q [$];
		int big_q [$];
		int j;
		int k;
		longint unsigned s;
		s = 0;
		for (int i = 0; i < n; i++) s += weight_mem[i];
		total_w = s;
		for (int i = 0; i < n; i++) begin
			thresh_mem[i] = longint'(n) * weight_mem[i];
			alias_mem[i] = i;
			if (thresh_mem[i] < s) small_q.push_back(i);
			else big_q.push_back(i);
		end
		// pair top small with top big; big drops to small once it runs short
		while (small_q.size() > 0 && big_q.size() > 0) begin
			k = big_q[$];
			j = small_q.pop_back();
			alias_mem[j] = k;
			thresh_mem[k] = thresh_mem[k] + thresh_mem[j] - s;
			if (thresh_mem[k] < s) begin
				void'(big_q.pop_back());
				small_q.push_back(k);
			end
		end
		built_n = n;
		tables_built = (s != 0);
	endfunction

	function automatic bit predict_draw(item_t it, output result_t r);
		longint unsigned x;
		longint unsigned idx;
		logic [127:0] lhs;
		logic [127:0] rhs;
		int pick;
		r = '0;
		case (it.mode)
			MODE_WRITE: begin
				weight_mem[it.entry_index] = it.weight;
				value_mem[it.entry_index] = it.entry_value;
				return 1'b0;
			end
			MODE_BUILD: begin
				build_alias(eff_count(count_reg));
				r.result_kind = KIND_BUILD;
				r.status = tables_built ? STATUS_OK : STATUS_ZERO;
				return 1'b1;
			end
			MODE_SAMPLE: begin
				r.result_kind = KIND_SAMPLE;
				if (!tables_built) begin
					r.status = STATUS_UNBUILT;
					return 1'b1;
				end
				x = longint'(built_n) * (2 * longint'(it.uniform) + 1);
				idx = x >> 33;
				if (idx >= built_n) idx = built_n - 1;
				lhs = 128'(x & 64'(FRAC_MASK)) * 128'(total_w);
				rhs = 128'(thresh_mem[idx]) << 33;
				pick = (lhs <= rhs) ? int'(idx) : alias_mem[idx];
				r.status = STATUS_OK;
				r.outcome_index = pick[IDX_W-1:0];
				r.outcome_value = value_mem[pick];
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	always @(posedge clk) begin
		result_t r;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
		if (cfg_valid && cfg_ready) begin
			count_reg = cfg_data;
			tables_built = 1'b0;
		end
		if (item_valid && item_ready) begin
			if (predict_draw(item, r)) pending_results.push_back(typed_en ? typed_res : r);
		end
		if (result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, result);
				errors++;
			end else begin
				r = pending_results.pop_front();
				if (result.result_kind !== r.result_kind) begin
					$display("%0t: result_kind expected %h actual %h", $time,
						r.result_kind, result.result_kind);
					errors++;
				end
				if (result.status !== r.status) begin
					$display("%0t: status expected %h actual %h", $time, r.status, result.status);
					errors++;
				end
				if (result.outcome_index !== r.outcome_index) begin
					$display("%0t: outcome_index expected %h actual %h", $time,
						r.outcome_index, result.outcome_index);
					errors++;
				end
				if (result.outcome_value !== r.outcome_value) begin
					$display("%0t: outcome_value expected %h actual %h", $time,
						r.outcome_value, result.outcome_value);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

	task automatic send_word(item_t it, bit use_typed, result_t tr);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item <= it;
		typed_en <= use_typed;
		typed_res <= tr;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		items_sent++;
		if (items_sent == ITEM_GOAL / 3) begin
			send_idle = 63;
			recv_idle = 17;
		end else if (items_sent == 2 * ITEM_GOAL / 3) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic send_plain(logic [1:0] m, logic [7:0] e, logic [15:0] w,
			logic [31:0] v, logic [31:0] u);
		send_word('{m, e, w, v, u}, 1'b0, '0);
	endtask

	// drain, let the block settle, then write the count
	task automatic write_count(logic [CNT_W-1:0] c);
		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_data <= c;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_weight(bit sparse);
		int p;
		p = $urandom_range(99);
		if (sparse || p < 10) return 16'd0;
		if (p < 20) return 16'hFFFF;
		if (p < 50) return 16'($urandom_range(15));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] rand_uniform();
		int p;
		p = $urandom_range(99);
		if (p < 5) return 32'd0;
		if (p < 10) return 32'hFFFF_FFFF;
		return $urandom;
	endfunction

	typedef struct {
		item_t it;
		bit use_typed;
		result_t res;
	} stim_row_t;

	initial begin
		stim_row_t rows [$];
		logic [CNT_W-1:0] count_plan [$];
		logic [CNT_W-1:0] c;
		int n;
		int p;
		bit zero_set;
		for (int i = 0; i < MAX_OUTCOMES; i++) begin
			weight_mem[i] = '0;
			value_mem[i] = '0;
			thresh_mem[i] = 0;
			alias_mem[i] = i;
		end
		rows = '{
			'{'{MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'h1234_5678}, 1'b1,
				'{KIND_SAMPLE, STATUS_UNBUILT, 8'd0, 32'd0}},
			'{'{MODE_BUILD, 8'd0, 16'd0, 32'd0, 32'd0}, 1'b1,
				'{KIND_BUILD, STATUS_ZERO, 8'd0, 32'd0}},
			'{'{MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1,
				'{KIND_SAMPLE, STATUS_UNBUILT, 8'd0, 32'd0}},
			'{'{MODE_UNUSED, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
			'{'{MODE_WRITE, 8'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
			'{'{MODE_WRITE, 8'hFF, 16'hFFFF, 32'hA5A5_5A5A, 32'd0}, 1'b0, '0},
			'{'{MODE_BUILD, 8'd0, 16'd0, 32'd0, 32'd0}, 1'b1,
				'{KIND_BUILD, STATUS_OK, 8'd0, 32'd0}},
			'{'{MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'd0}, 1'b1,
				'{KIND_SAMPLE, STATUS_OK, 8'd0, 32'hFFFF_FFFF}},
			'{'{MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1,
				'{KIND_SAMPLE, STATUS_OK, 8'd0, 32'hFFFF_FFFF}},
			// value rewrite after build shows up at once
			'{'{MODE_WRITE, 8'd0, 16'd1, 32'h1357_9BDF, 32'd0}, 1'b0, '0},
			'{'{MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'h8000_0000}, 1'b1,
				'{KIND_SAMPLE, STATUS_OK, 8'd0, 32'h1357_9BDF}},
			'{'{MODE_WRITE, 8'd1, 16'd3, 32'h0000_0001, 32'd0}, 1'b0, '0},
			'{'{MODE_WRITE, 8'd2, 16'd0, 32'h0000_0002, 32'd0}, 1'b0, '0},
			'{'{MODE_WRITE, 8'd3, 16'hFFFF, 32'h0000_0003, 32'd0}, 1'b0, '0}
		};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (rows[i]) send_word(rows[i].it, rows[i].use_typed, rows[i].res);

		write_count(9'd4);
		send_plain(MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'd0);
		send_plain(MODE_BUILD, 8'd0, 16'd0, 32'd0, 32'd0);
		foreach (rows[i]) if (rows[i].it.mode == MODE_SAMPLE)
			send_plain(MODE_SAMPLE, 8'd0, 16'd0, 32'd0, rows[i].it.uniform);
		send_plain(MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'h3FFF_FFFF);
		send_plain(MODE_SAMPLE, 8'd0, 16'd0, 32'd0, 32'hC000_0000);

		count_plan = '{9'd0, 9'd2, 9'd256, 9'd3, 9'd511, 9'd5, 9'd300, 9'd8, 9'd16, 9'd1};
		while (items_sent < ITEM_GOAL) begin
			c = (count_plan.size() > 0) ? count_plan.pop_front() : 9'($urandom_range(2, 20));
			write_count(c);
			n = eff_count(c);
			zero_set = ($urandom_range(7) == 0);
			if ($urandom_range(3) == 0) send_plain(MODE_SAMPLE, 8'($urandom), 16'($urandom),
				$urandom, $urandom);
			for (int i = 0; i < n; i++)
				send_plain(MODE_WRITE, 8'(i), rand_weight(zero_set), $urandom, $urandom);
			send_plain(MODE_BUILD, 8'($urandom), 16'($urandom), $urandom, $urandom);
			// hold off until the build word has come back
			if ($urandom_range(3) == 0) begin
				@(negedge clk);
				item_valid <= 1'b0;
				wait (pending_results.size() == 0);
			end
			repeat ($urandom_range(20, 40)) begin
				p = $urandom_range(99);
				if (p < 85)
					send_plain(MODE_SAMPLE, 8'($urandom), 16'($urandom), $urandom,
						rand_uniform());
				else if (p < 92)
					send_plain(MODE_WRITE, 8'($urandom), rand_weight(1'b0), $urandom,
						$urandom);
				else if (p < 96)
					send_plain(MODE_UNUSED, 8'($urandom), 16'($urandom), $urandom, $urandom);
				else
					send_plain(MODE_BUILD, 8'($urandom), 16'($urandom), $urandom, $urandom);
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- alias_table_sampler.f -----
rtl/core/atsmp_pkg.sv
rtl/core/atsmp_alu.sv
rtl/core/alias_table_sampler.sv
tb/sv/tb_alias_table_sampler.sv
